[hw/rtl/ansi_escape_terminal_decoder_assert.svh]
// Assertion macros for the escape-sequence decoder.
`ifndef ANSI_ESCAPE_TERMINAL_DECODER_ASSERT_SVH
`define ANSI_ESCAPE_TERMINAL_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AETD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aetd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AETD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aetd assertion failed");

`endif

[hw/rtl/aetd_pkg.sv]
// Package: types and constants for the escape-sequence decoder.
package aetd_pkg;

    localparam int CHAR_W = 7;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ATTR_W = 6;
    localparam int CLR_W  = 3;
    localparam int CNT_W  = 4;
    localparam int OP_W   = 4;
    localparam int POS_W  = 11;

    localparam int DEF_SCREEN_ROWS = 24;
    localparam int DEF_SCREEN_COLS = 80;

    localparam logic [CHAR_W-1:0] CH_BEL = 7'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 7'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 7'h0a;
    localparam logic [CHAR_W-1:0] CH_CR  = 7'h0d;
    localparam logic [CHAR_W-1:0] CH_SO  = 7'h0e;
    localparam logic [CHAR_W-1:0] CH_SI  = 7'h0f;
    localparam logic [CHAR_W-1:0] CH_ESC = 7'h1b;
    localparam logic [CHAR_W-1:0] CH_SP  = 7'h20;
    localparam logic [CHAR_W-1:0] CH_LBR = 7'h5b;
    localparam logic [CHAR_W-1:0] CH_A   = 7'h41;
    localparam logic [CHAR_W-1:0] CH_C   = 7'h43;
    localparam logic [CHAR_W-1:0] CH_H   = 7'h48;
    localparam logic [CHAR_W-1:0] CH_J   = 7'h4a;
    localparam logic [CHAR_W-1:0] CH_K   = 7'h4b;
    localparam logic [CHAR_W-1:0] CH_L   = 7'h4c;
    localparam logic [CHAR_W-1:0] CH_M   = 7'h4d;
    localparam logic [CHAR_W-1:0] CH_P   = 7'h50;
    localparam logic [CHAR_W-1:0] CH_AT  = 7'h40;
    localparam logic [CHAR_W-1:0] CH_SGR = 7'h6d;
    localparam logic [CHAR_W-1:0] CH_D0  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_D1  = 7'h31;
    localparam logic [CHAR_W-1:0] CH_D3  = 7'h33;
    localparam logic [CHAR_W-1:0] CH_D4  = 7'h34;
    localparam logic [CHAR_W-1:0] CH_D5  = 7'h35;
    localparam logic [CHAR_W-1:0] CH_D7  = 7'h37;
    localparam logic [CHAR_W-1:0] CH_D8  = 7'h38;

    // 10*'0' + '0' + 1: bias of a two-digit position field
    localparam logic [POS_W-1:0] POS_BIAS = 11'd529;

    localparam int AT_BOLD  = 0;
    localparam int AT_UNDER = 1;
    localparam int AT_BLINK = 2;
    localparam int AT_REV   = 3;
    localparam int AT_INVIS = 4;
    localparam int AT_ALT   = 5;

    localparam logic [CLR_W-1:0] FG_RESET = 3'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 3'd0;

    localparam logic [2:0] REG_PANEL_VISIBLE = 3'd0;

    typedef enum logic [OP_W-1:0] {
        OP_NONE      = 4'd0,
        OP_PUT       = 4'd1,
        OP_BELL      = 4'd2,
        OP_SCROLL    = 4'd3,
        OP_CLR_EOS   = 4'd4,
        OP_CLR_EOL   = 4'd5,
        OP_INS_LINE  = 4'd6,
        OP_DEL_LINE  = 4'd7,
        OP_DEL_CHAR  = 4'd8,
        OP_INS_BLANK = 4'd9
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] glyph;
        logic [ROW_W-1:0]  op_row;
        logic [COL_W-1:0]  op_col;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic [ATTR_W-1:0] attr;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
        logic              cdef;
    } res_t;

endpackage

[hw/rtl/ansi_escape_terminal_decoder.sv]
// Top level: escape-sequence decoder producing one display command per character.
//
//  channel | signals                               | transfer when
//  --------+---------------------------------------+--------------------------
//  in      | in_valid, in_ready, char_in           | in_valid && in_ready
//  out     | out_valid, out_ready, op .. color_def | out_valid && out_ready
//  cfg     | APB psel/penable/pwrite/paddr/pwdata  | psel && penable && pwrite
//
// One character per cycle unless out stalls; input, then result register.
// Decode state updates as the input register moves into the result register.
// A stalled result holds the input register; the input side frees when out moves.
// Reset clears the cursor, attributes and sequence count; colors go to defaults.
module ansi_escape_terminal_decoder #(
    parameter int SCREEN_ROWS = aetd_pkg::DEF_SCREEN_ROWS,
    parameter int SCREEN_COLS = aetd_pkg::DEF_SCREEN_COLS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  char_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [aetd_pkg::OP_W-1:0]   op,
    output logic [aetd_pkg::CHAR_W-1:0] glyph,
    output logic [aetd_pkg::ROW_W-1:0]  op_row,
    output logic [aetd_pkg::COL_W-1:0]  op_col,
    output logic [aetd_pkg::ROW_W-1:0]  cursor_row_out,
    output logic [aetd_pkg::COL_W-1:0]  cursor_col_out,
    output logic [aetd_pkg::ATTR_W-1:0] attr_bits,
    output logic [aetd_pkg::CLR_W-1:0]  fg_out,
    output logic [aetd_pkg::CLR_W-1:0]  bg_out,
    output logic                        color_default,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [aetd_pkg::ROW_W-1:0] LAST_ROW = aetd_pkg::ROW_W'(SCREEN_ROWS - 1);
    localparam logic [aetd_pkg::COL_W-1:0] LAST_COL = aetd_pkg::COL_W'(SCREEN_COLS - 1);
    localparam logic [aetd_pkg::POS_W-1:0] ROW_LIM  =
        aetd_pkg::POS_W'(529 + SCREEN_ROWS);
    localparam logic [aetd_pkg::POS_W-1:0] COL_LIM  =
        aetd_pkg::POS_W'(529 + SCREEN_COLS);

    // configuration
    logic panel_visible_reg;
    logic cfg_write;

    // pipeline control
    logic                        s1_valid_reg;
    logic [aetd_pkg::CHAR_W-1:0] s1_char_reg;
    logic                        out_valid_reg;
    aetd_pkg::res_t              res_reg;
    aetd_pkg::res_t              res_next;
    logic                        advance;

    // decoder state
    logic [aetd_pkg::CNT_W-1:0]  seq_count_reg, seq_count_next;
    logic [aetd_pkg::CHAR_W-1:0] b2_reg, b2_next;
    logic [aetd_pkg::CHAR_W-1:0] b3_reg, b3_next;
    logic [aetd_pkg::CHAR_W-1:0] b5_reg, b5_next;
    logic [aetd_pkg::CHAR_W-1:0] b6_reg, b6_next;
    logic [aetd_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [aetd_pkg::COL_W-1:0]  col_reg, col_next;
    logic [aetd_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [aetd_pkg::CLR_W-1:0]  fg_reg, fg_next;
    logic [aetd_pkg::CLR_W-1:0]  bg_reg, bg_next;
    logic                        cdef_reg, cdef_next;

    // cursor-position decode
    logic [aetd_pkg::POS_W-1:0]  pos_row;
    logic [aetd_pkg::POS_W-1:0]  pos_col;
    logic [aetd_pkg::POS_W-1:0]  pos_row_off;
    logic [aetd_pkg::POS_W-1:0]  pos_col_off;
    logic                        pos_ok;

    logic [aetd_pkg::CHAR_W-1:0] c;
    aetd_pkg::op_t               op_sel;
    logic [aetd_pkg::CHAR_W-1:0] glyph_sel;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == aetd_pkg::REG_PANEL_VISIBLE[2])
        begin
            prdata = {31'd0, panel_visible_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_visible_reg <= 1'b1;
        end
        else if (cfg_write && paddr[2] == aetd_pkg::REG_PANEL_VISIBLE[2])
        begin
            panel_visible_reg <= pwdata[0];
        end
    end

    // ---------------- handshake ----------------
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // ---------------- decode ----------------
    assign c = s1_char_reg;

    assign pos_row = {1'b0, b2_reg, 3'b000} + {3'b000, b2_reg, 1'b0} + {4'b0000, b3_reg};
    assign pos_col = {1'b0, b5_reg, 3'b000} + {3'b000, b5_reg, 1'b0} + {4'b0000, b6_reg};
    assign pos_row_off = pos_row - aetd_pkg::POS_BIAS;
    assign pos_col_off = pos_col - aetd_pkg::POS_BIAS;
    assign pos_ok = (pos_row >= aetd_pkg::POS_BIAS) && (pos_row < ROW_LIM) &&
                    (pos_col >= aetd_pkg::POS_BIAS) && (pos_col < COL_LIM);

    always_comb
    begin
        seq_count_next = seq_count_reg;
        b2_next        = b2_reg;
        b3_next        = b3_reg;
        b5_next        = b5_reg;
        b6_next        = b6_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        attr_next      = attr_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        cdef_next      = cdef_reg;
        op_sel         = aetd_pkg::OP_NONE;
        glyph_sel      = '0;

        case (seq_count_reg)
            4'd0:
            begin
                case (c)
                    aetd_pkg::CH_ESC: seq_count_next = 4'd1;
                    aetd_pkg::CH_BEL:
                    begin
                        if (panel_visible_reg)
                        begin
                            op_sel = aetd_pkg::OP_BELL;
                        end
                    end
                    aetd_pkg::CH_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                        end
                    end
                    aetd_pkg::CH_LF:
                    begin
                        if (row_reg < LAST_ROW)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            op_sel = aetd_pkg::OP_SCROLL;
                        end
                    end
                    aetd_pkg::CH_CR: col_next = '0;
                    aetd_pkg::CH_SO: attr_next[aetd_pkg::AT_ALT] = 1'b1;
                    aetd_pkg::CH_SI: attr_next[aetd_pkg::AT_ALT] = 1'b0;
                    default:
                    begin
                        if (c >= aetd_pkg::CH_SP)
                        begin
                            op_sel    = aetd_pkg::OP_PUT;
                            glyph_sel = c;
                            if (col_reg < LAST_COL)
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
            4'd1:
            begin
                seq_count_next = (c == aetd_pkg::CH_LBR) ? 4'd2 : 4'd0;
            end
            4'd2:
            begin
                b2_next        = c;
                seq_count_next = 4'd0;
                case (c)
                    aetd_pkg::CH_A:
                    begin
                        if (row_reg != '0)
                        begin
                            row_next = row_reg - 1'b1;
                        end
                    end
                    aetd_pkg::CH_C:
                    begin
                        if (col_reg < LAST_COL)
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    aetd_pkg::CH_H:
                    begin
                        row_next = '0;
                        col_next = '0;
                    end
                    aetd_pkg::CH_J:
                    begin
                        if (row_reg == '0 && col_reg == '0)
                        begin
                            attr_next = '0;
                            fg_next   = aetd_pkg::FG_RESET;
                            bg_next   = aetd_pkg::BG_RESET;
                            cdef_next = 1'b0;
                        end
                        op_sel = aetd_pkg::OP_CLR_EOS;
                    end
                    aetd_pkg::CH_K:  op_sel = aetd_pkg::OP_CLR_EOL;
                    aetd_pkg::CH_L:  op_sel = aetd_pkg::OP_INS_LINE;
                    aetd_pkg::CH_M:  op_sel = aetd_pkg::OP_DEL_LINE;
                    aetd_pkg::CH_P:  op_sel = aetd_pkg::OP_DEL_CHAR;
                    aetd_pkg::CH_AT: op_sel = aetd_pkg::OP_INS_BLANK;
                    default:         seq_count_next = 4'd3;
                endcase
            end
            4'd3:
            begin
                b3_next        = c;
                seq_count_next = 4'd4;
                if (c == aetd_pkg::CH_SGR)
                begin
                    case (b2_reg)
                        aetd_pkg::CH_D0:
                        begin
                            attr_next      = '0;
                            cdef_next      = 1'b1;
                            seq_count_next = 4'd0;
                        end
                        aetd_pkg::CH_D1:
                        begin
                            attr_next[aetd_pkg::AT_BOLD] = 1'b1;
                            seq_count_next               = 4'd0;
                        end
                        aetd_pkg::CH_D4:
                        begin
                            attr_next[aetd_pkg::AT_UNDER] = 1'b1;
                            seq_count_next                = 4'd0;
                        end
                        aetd_pkg::CH_D5:
                        begin
                            attr_next[aetd_pkg::AT_BLINK] = 1'b1;
                            seq_count_next                = 4'd0;
                        end
                        aetd_pkg::CH_D7:
                        begin
                            attr_next[aetd_pkg::AT_REV] = 1'b1;
                            seq_count_next              = 4'd0;
                        end
                        aetd_pkg::CH_D8:
                        begin
                            attr_next[aetd_pkg::AT_INVIS] = 1'b1;
                            seq_count_next                = 4'd0;
                        end
                        default:
                        begin
                            seq_count_next = 4'd4;
                        end
                    endcase
                end
            end
            4'd4:
            begin
                seq_count_next = 4'd5;
                if (c == aetd_pkg::CH_SGR && b3_reg >= aetd_pkg::CH_D0 &&
                    b3_reg <= aetd_pkg::CH_D7)
                begin
                    // digit value is the low three bits of '0'..'7'
                    if (b2_reg == aetd_pkg::CH_D3)
                    begin
                        fg_next        = b3_reg[aetd_pkg::CLR_W-1:0];
                        cdef_next      = 1'b0;
                        seq_count_next = 4'd0;
                    end
                    else if (b2_reg == aetd_pkg::CH_D4)
                    begin
                        bg_next        = b3_reg[aetd_pkg::CLR_W-1:0];
                        cdef_next      = 1'b0;
                        seq_count_next = 4'd0;
                    end
                end
            end
            4'd5:
            begin
                b5_next        = c;
                seq_count_next = 4'd6;
            end
            4'd6:
            begin
                b6_next        = c;
                seq_count_next = 4'd7;
            end
            4'd7:
            begin
                seq_count_next = 4'd8;
                if (c == aetd_pkg::CH_H)
                begin
                    if (pos_ok)
                    begin
                        row_next = pos_row_off[aetd_pkg::ROW_W-1:0];
                        col_next = pos_col_off[aetd_pkg::COL_W-1:0];
                    end
                    seq_count_next = 4'd0;
                end
            end
            default:
            begin
                // full buffer: drop this byte and end the sequence
                seq_count_next = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        res_next.op      = op_sel;
        res_next.glyph   = glyph_sel;
        res_next.op_row  = (op_sel == aetd_pkg::OP_NONE) ? '0 : row_reg;
        res_next.op_col  = (op_sel == aetd_pkg::OP_NONE) ? '0 : col_reg;
        res_next.cur_row = row_next;
        res_next.cur_col = col_next;
        res_next.attr    = attr_next;
        res_next.fg      = fg_next;
        res_next.bg      = bg_next;
        res_next.cdef    = cdef_next;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_count_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= '0;
            fg_reg        <= aetd_pkg::FG_RESET;
            bg_reg        <= aetd_pkg::BG_RESET;
            cdef_reg      <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                seq_count_reg <= seq_count_next;
                row_reg       <= row_next;
                col_reg       <= col_next;
                attr_reg      <= attr_next;
                fg_reg        <= fg_next;
                bg_reg        <= bg_next;
                cdef_reg      <= cdef_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_char_reg <= char_in[aetd_pkg::CHAR_W-1:0];
        end
        if (advance)
        begin
            res_reg <= res_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            b5_reg  <= b5_next;
            b6_reg  <= b6_next;
        end
    end

    // ---------------- outputs ----------------
    assign out_valid      = out_valid_reg;
    assign op             = res_reg.op;
    assign glyph          = res_reg.glyph;
    assign op_row         = res_reg.op_row;
    assign op_col         = res_reg.op_col;
    assign cursor_row_out = res_reg.cur_row;
    assign cursor_col_out = res_reg.cur_col;
    assign attr_bits      = res_reg.attr;
    assign fg_out         = res_reg.fg;
    assign bg_out         = res_reg.bg;
    assign color_default  = res_reg.cdef;

    // ---------------- assertions ----------------
`include "ansi_escape_terminal_decoder_assert.svh"

    `AETD_ASSERT_NOW(a_seq_count_range, 1'b1, seq_count_reg <= 4'd8)
    `AETD_ASSERT_NOW(a_cursor_on_screen, 1'b1, row_reg <= LAST_ROW && col_reg <= LAST_COL)
    `AETD_ASSERT_NOW(a_no_op_no_pos, out_valid_reg && res_reg.op == aetd_pkg::OP_NONE,
        res_reg.op_row == '0 && res_reg.op_col == '0)
    `AETD_ASSERT_NEXT(a_stall_holds_state, out_valid_reg && !out_ready,
        $stable(row_reg) && $stable(col_reg) && $stable(seq_count_reg))

endmodule
